// File: rtl/core/dapt_pkg.sv
// Package for the dual axis PID tracker: widths, constants, sequencer states
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package dapt_pkg;

  localparam int PIX_W     = 12;          // pixel coordinate width
  localparam int W         = 56;          // working width of the shared datapath
  localparam int GAIN_W    = 16;          // multiplier coefficient width
  localparam int MUL_STEPS = GAIN_W;
  localparam int DIV_STEPS = 36;          // numerator magnitude bits
  localparam int DEN_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 18;

  localparam logic [15:0] CENTRE_ANGLE = 16'd23040;
  localparam logic [31:0] DT_MIN       = 32'd5;
  localparam logic [31:0] DT_MAX       = 32'd100;
  localparam logic [15:0] MS_PER_S     = 16'd1000;
  localparam logic [15:0] FULL_SCALE   = 16'd46080;
  localparam int          PULSE_SPAN   = 2000;
  localparam logic [12:0] PULSE_BASE   = 13'd500;
  localparam logic [12:0] PULSE_TOP    = 13'd2500;
  localparam logic signed [W-1:0] E_MAX = W'(64'sd8388607);
  localparam logic signed [W-1:0] E_MIN = -W'(64'sd8388608);

  localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ILIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DT, ST_LOST, ST_ERR, ST_IMUL, ST_IDIV, ST_DMUL, ST_DDIV,
    ST_KP, ST_KI, ST_KD, ST_PULSE, ST_OUT
  } state_t;

  typedef struct packed {
    state_t step;
    logic   axis;
    logic   start;
    logic   commit;
    logic   load;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic lost;
    logic out_free;
  } sts_t;

  function automatic logic is_unit(state_t s);
    return (s == ST_ERR) || (s == ST_IMUL) || (s == ST_IDIV) || (s == ST_DMUL) ||
           (s == ST_DDIV) || (s == ST_KP) || (s == ST_KI) || (s == ST_KD) ||
           (s == ST_PULSE);
  endfunction

endpackage

// File: rtl/core/dapt_if.sv
// Valid/ready channel interfaces for the tracker's input and result words.
// Depends on dapt_pkg.
`timescale 1ns / 1ps
interface dapt_in_if;
  import dapt_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] measured_x;
  logic [PIX_W-1:0] wanted_x;
  logic [PIX_W-1:0] measured_y;
  logic [PIX_W-1:0] wanted_y;
  logic [31:0]      tick_ms;
  modport source(output valid, measured_x, wanted_x, measured_y, wanted_y, tick_ms,
                 input ready);
  modport sink(input valid, measured_x, wanted_x, measured_y, wanted_y, tick_ms,
               output ready);
endinterface

interface dapt_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        angle_h;
  logic [15:0]        angle_v;
  logic [11:0]        pulse_h;
  logic [11:0]        pulse_v;
  logic signed [13:0] correction_h;
  logic signed [13:0] correction_v;
  logic               target_lost;
  modport source(output valid, angle_h, angle_v, pulse_h, pulse_v, correction_h,
                 correction_v, target_lost, input ready);
  modport sink(input valid, angle_h, angle_v, pulse_h, pulse_v, correction_h,
               correction_v, target_lost, output ready);
endinterface

// File: rtl/core/dual_axis_pid_tracker.sv
// Dual axis PID tracker, top level. Each accepted word carries measured and
// goal pixel positions for both axes plus a millisecond timestamp and gives
// exactly one result word with new servo angles, pulse widths and the clamped
// corrections. Words are handled one at a time: a tracked frame makes, per
// axis, six passes through the 16-step shared multiplier and three through
// the 36-step shared divider; a frame with the target lost makes only the
// two pulse divisions. A new word is accepted as soon as the previous result
// sits in the output register. Configuration writes go to cfg_index 0..7;
// the user must make them only while idle, as the block does not enforce it.
`timescale 1ns / 1ps
module dual_axis_pid_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  dapt_in_if.sink                        in_ch,
  dapt_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [dapt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dapt_pkg::CFG_W-1:0]     cfg_data
);
  import dapt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dapt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  dapt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .measured_x(in_ch.measured_x), .wanted_x(in_ch.wanted_x),
    .measured_y(in_ch.measured_y), .wanted_y(in_ch.wanted_y),
    .tick_ms(in_ch.tick_ms),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .angle_h(out_ch.angle_h), .angle_v(out_ch.angle_v),
    .pulse_h(out_ch.pulse_h), .pulse_v(out_ch.pulse_v),
    .correction_h(out_ch.correction_h), .correction_v(out_ch.correction_v),
    .target_lost(out_ch.target_lost)
  );
endmodule

// File: rtl/core/dapt_mul.sv
// Shift-add multiplier: unsigned 16-bit coefficient times signed operand,
// one coefficient bit per cycle. Depends on dapt_pkg.
`timescale 1ns / 1ps
module dapt_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [dapt_pkg::GAIN_W-1:0]    a,
  input  logic signed [dapt_pkg::W-1:0]  b,
  output logic                           done,
  output logic signed [dapt_pkg::W-1:0]  p
);
  import dapt_pkg::*;
  localparam int CNT_W = $clog2(MUL_STEPS + 1);

  logic [GAIN_W-1:0]   a_r;
  logic signed [W-1:0] b_r, p_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(MUL_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (cnt_r != '0) begin
      if (a_r[0]) p_r <= p_r + b_r;
      b_r <= b_r <<< 1;
      a_r <= a_r >> 1;
    end
  end

  assign done = done_r;
  assign p    = p_r;

  always_ff @(posedge clk) begin
    if (rst_n) assert (!(start && cnt_r != '0))
      else $error("multiplier restarted while busy");
  end
endmodule

// File: rtl/core/dapt_div.sv
// Restoring divider with floor rounding: signed numerator, positive divisor,
// one quotient bit per cycle. Depends on dapt_pkg.
`timescale 1ns / 1ps
module dapt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [dapt_pkg::W-1:0]  n,
  input  logic [dapt_pkg::DEN_W-1:0]     d,
  output logic                           done,
  output logic signed [dapt_pkg::W-1:0]  q
);
  import dapt_pkg::*;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [DIV_STEPS-1:0] num_r;
  logic [DEN_W-1:0]     rem_r, den_r;
  logic                 neg_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;
  logic signed [W-1:0]  mag;
  logic [DEN_W:0]       trial;
  logic                 fit;
  logic [W-1:0]         quot;

  assign mag   = n[W-1] ? -n : n;
  assign trial = {rem_r, num_r[DIV_STEPS-1]};
  assign fit   = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= mag[DIV_STEPS-1:0];
      rem_r <= '0;
      den_r <= d;
      neg_r <= n[W-1];
    end else if (cnt_r != '0) begin
      rem_r <= fit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      num_r <= {num_r[DIV_STEPS-2:0], fit};
    end
  end

  // floor: a negative quotient with a remainder rounds one further down
  assign quot = W'(num_r) + W'(neg_r && rem_r != '0);
  assign q    = neg_r ? -$signed(quot) : $signed(quot);
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (rst_n) assert (!(start && cnt_r != '0))
      else $error("divider restarted while busy");
  end
endmodule

// File: rtl/core/dapt_ctrl.sv
// Sequencer for the tracker: steps each frame through the shared multiplier
// and divider, axis by axis. Depends on dapt_pkg.
`timescale 1ns / 1ps
module dapt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dapt_pkg::sts_t sts,
  output dapt_pkg::cmd_t cmd
);
  import dapt_pkg::*;

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;
  logic   issued_r, issued_nxt;
  logic   adv;

  always_comb begin
    if (is_unit(state_r))        adv = issued_r && sts.unit_done;
    else if (state_r == ST_OUT)  adv = sts.out_free;
    else if (state_r == ST_IDLE) adv = in_valid;
    else                         adv = 1'b1;
  end

  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    issued_nxt = issued_r;
    if (is_unit(state_r) && !issued_r) issued_nxt = 1'b1;
    if (adv) begin
      issued_nxt = 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          state_nxt = ST_DT;
          axis_nxt  = 1'b0;
        end
        ST_DT:   state_nxt = sts.lost ? ST_LOST : ST_ERR;
        ST_LOST: state_nxt = ST_PULSE;
        ST_ERR:  state_nxt = ST_IMUL;
        ST_IMUL: state_nxt = ST_IDIV;
        ST_IDIV: state_nxt = ST_DMUL;
        ST_DMUL: state_nxt = ST_DDIV;
        ST_DDIV: state_nxt = ST_KP;
        ST_KP:   state_nxt = ST_KI;
        ST_KI:   state_nxt = ST_KD;
        ST_KD:   state_nxt = ST_PULSE;
        ST_PULSE: begin
          if (!axis_r) begin
            axis_nxt  = 1'b1;
            state_nxt = sts.lost ? ST_PULSE : ST_ERR;
          end else begin
            state_nxt = ST_OUT;
          end
        end
        ST_OUT:  state_nxt = ST_IDLE;
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.step   = state_r;
    cmd.axis   = axis_r;
    cmd.start  = is_unit(state_r) && !issued_r;
    cmd.commit = adv && (state_r != ST_IDLE);
    cmd.load   = (state_r == ST_IDLE) && in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      axis_r   <= 1'b0;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      axis_r   <= axis_nxt;
      issued_r <= issued_nxt;
    end
  end

  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !cmd.start) else $error("unit started twice in a row");
  a_accept_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_DT) else $error("accept did not start frame");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && cmd.commit) |=> state_r == ST_IDLE)
    else $error("result handed off without return to idle");
  a_commit_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_unit(state_r)) |-> issued_r) else $error("commit before issue");
endmodule

// File: rtl/core/dapt_dp.sv
// Datapath for the tracker: configuration registers, per-axis PID state,
// operand selection for the shared multiplier and divider, result register.
// Depends on dapt_pkg, dapt_mul, dapt_div.
`timescale 1ns / 1ps
module dapt_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dapt_pkg::cmd_t                cmd,
  output dapt_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [dapt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dapt_pkg::CFG_W-1:0]    cfg_data,
  input  logic [dapt_pkg::PIX_W-1:0]    measured_x,
  input  logic [dapt_pkg::PIX_W-1:0]    wanted_x,
  input  logic [dapt_pkg::PIX_W-1:0]    measured_y,
  input  logic [dapt_pkg::PIX_W-1:0]    wanted_y,
  input  logic [31:0]                   tick_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   angle_h,
  output logic [15:0]                   angle_v,
  output logic [11:0]                   pulse_h,
  output logic [11:0]                   pulse_v,
  output logic signed [13:0]            correction_h,
  output logic signed [13:0]            correction_v,
  output logic                          target_lost
);
  import dapt_pkg::*;

  // configuration
  logic [15:0] kp_r, ki_r, kd_r, scale_r, floor_r, ceil_r;
  logic [12:0] clim_r;
  logic [17:0] ilim_r;

  // captured word
  logic [PIX_W-1:0] mx_r, wx_r, my_r, wy_r;
  logic [31:0]      tick_r;

  // loop state
  logic signed [19:0] integ_r [2];
  logic signed [23:0] prev_r  [2];
  logic [15:0]        angle_r [2];
  logic [31:0]        last_tick_r;

  // work registers
  logic [6:0]          dt_r;
  logic signed [23:0]  e_r;
  logic signed [19:0]  i_r;
  logic signed [W-1:0] d_r, acc_r;
  logic signed [13:0]  corr_r  [2];
  logic [11:0]         pulse_r [2];

  logic                out_valid_r;
  logic [15:0]         o_ang_h_r, o_ang_v_r;
  logic [11:0]         o_pul_h_r, o_pul_v_r;
  logic signed [13:0]  o_cor_h_r, o_cor_v_r;
  logic                o_lost_r;

  logic                lost;
  logic signed [PIX_W:0] werr;
  logic [31:0]         tdiff;
  logic [6:0]          dt_new;
  logic [GAIN_W-1:0]   mul_a;
  logic signed [W-1:0] mul_b, mul_p, div_n, div_q;
  logic [DEN_W-1:0]    div_d;
  logic                mul_done, div_done;
  logic                mul_go, div_go;
  logic                ax;
  logic signed [W-1:0] e_w, e_sat, i_sum, i_lim, i_new;
  logic signed [W-1:0] acc_sum, u_w, c_lim, u_new;
  logic signed [17:0]  ang_t;
  logic [15:0]         ang_new;
  logic [12:0]         pul_sum;

  assign ax   = cmd.axis;
  assign lost = (mx_r == '0) && (my_r == '0);

  assign werr = ax ? ($signed({1'b0, wy_r}) - $signed({1'b0, my_r}))
                   : ($signed({1'b0, wx_r}) - $signed({1'b0, mx_r}));

  assign tdiff  = tick_r - last_tick_r;
  assign dt_new = (tdiff < DT_MIN) ? 7'(DT_MIN) : (tdiff > DT_MAX) ? 7'(DT_MAX) : tdiff[6:0];

  // operand selection for the shared units
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    div_n  = '0;
    div_d  = '0;
    mul_go = 1'b0;
    div_go = 1'b0;
    unique case (cmd.step)
      ST_ERR: begin
        mul_go = cmd.start;
        mul_a  = scale_r;
        mul_b  = {{(W-PIX_W-1){werr[PIX_W]}}, werr};
      end
      ST_IMUL: begin
        mul_go = cmd.start;
        mul_a  = GAIN_W'(dt_r);
        mul_b  = {{(W-24){e_r[23]}}, e_r};
      end
      ST_DMUL: begin
        mul_go = cmd.start;
        mul_a  = MS_PER_S;
        mul_b  = {{(W-24){e_r[23]}}, e_r} - {{(W-24){prev_r[ax][23]}}, prev_r[ax]};
      end
      ST_KP: begin
        mul_go = cmd.start;
        mul_a  = kp_r;
        mul_b  = {{(W-24){e_r[23]}}, e_r};
      end
      ST_KI: begin
        mul_go = cmd.start;
        mul_a  = ki_r;
        mul_b  = {{(W-20){i_r[19]}}, i_r};
      end
      ST_KD: begin
        mul_go = cmd.start;
        mul_a  = kd_r;
        mul_b  = d_r;
      end
      ST_IDIV: begin
        div_go = cmd.start;
        div_n  = mul_p;
        div_d  = MS_PER_S;
      end
      ST_DDIV: begin
        div_go = cmd.start;
        div_n  = mul_p;
        div_d  = DEN_W'(dt_r);
      end
      ST_PULSE: begin
        div_go = cmd.start;
        div_n  = $signed(W'({11'd0, angle_r[ax]} * 27'(PULSE_SPAN)));
        div_d  = FULL_SCALE;
      end
      ST_IDLE, ST_DT, ST_LOST, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  dapt_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  dapt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .n(div_n), .d(div_d),
    .done(div_done), .q(div_q)
  );

  // error in degrees, saturated to 24 bits
  assign e_w   = mul_p >>> 8;
  assign e_sat = (e_w > E_MAX) ? E_MAX : (e_w < E_MIN) ? E_MIN : e_w;

  assign i_sum = {{(W-20){integ_r[ax][19]}}, integ_r[ax]} + div_q;
  assign i_lim = {{(W-18){1'b0}}, ilim_r};
  assign i_new = (i_sum < -i_lim) ? -i_lim : (i_sum > i_lim) ? i_lim : i_sum;

  assign acc_sum = acc_r + mul_p;
  assign u_w     = acc_sum >>> 12;
  assign c_lim   = {{(W-13){1'b0}}, clim_r};
  assign u_new   = (u_w < -c_lim) ? -c_lim : (u_w > c_lim) ? c_lim : u_w;

  assign ang_t   = $signed({2'b00, angle_r[ax]}) + {{4{u_new[13]}}, u_new[13:0]};
  always_comb begin
    priority if (ang_t < $signed({2'b00, floor_r})) ang_new = floor_r;
    else if (ang_t > $signed({2'b00, ceil_r}))      ang_new = ceil_r;
    else                                            ang_new = ang_t[15:0];
  end

  assign pul_sum = div_q[12:0] + PULSE_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= 16'd410;
      ki_r    <= 16'd41;
      kd_r    <= 16'd205;
      scale_r <= 16'd6554;
      clim_r  <= 13'd1280;
      ilim_r  <= 18'd128000;
      floor_r <= 16'd11520;
      ceil_r  <= 16'd46080;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KP:    kp_r    <= cfg_data[15:0];
        CFG_KI:    ki_r    <= cfg_data[15:0];
        CFG_KD:    kd_r    <= cfg_data[15:0];
        CFG_SCALE: scale_r <= cfg_data[15:0];
        CFG_CLIM:  clim_r  <= cfg_data[12:0];
        CFG_ILIM:  ilim_r  <= cfg_data[17:0];
        CFG_FLOOR: floor_r <= cfg_data[15:0];
        CFG_CEIL:  ceil_r  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mx_r   <= measured_x;
      wx_r   <= wanted_x;
      my_r   <= measured_y;
      wy_r   <= wanted_y;
      tick_r <= tick_ms;
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r[0]  <= '0;
      integ_r[1]  <= '0;
      prev_r[0]   <= '0;
      prev_r[1]   <= '0;
      angle_r[0]  <= CENTRE_ANGLE;
      angle_r[1]  <= CENTRE_ANGLE;
      last_tick_r <= '0;
    end else if (cmd.commit) begin
      unique case (cmd.step)
        ST_DT: last_tick_r <= tick_r;
        ST_LOST: begin
          integ_r[0] <= '0;
          integ_r[1] <= '0;
          prev_r[0]  <= '0;
          prev_r[1]  <= '0;
          angle_r[0] <= CENTRE_ANGLE;
          angle_r[1] <= CENTRE_ANGLE;
        end
        ST_KD: begin
          integ_r[ax] <= i_r;
          prev_r[ax]  <= e_r;
          angle_r[ax] <= ang_new;
        end
        ST_IDLE, ST_ERR, ST_IMUL, ST_IDIV, ST_DMUL, ST_DDIV, ST_KP, ST_KI,
        ST_PULSE, ST_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      unique case (cmd.step)
        ST_DT:   dt_r <= dt_new;
        ST_LOST: begin
          corr_r[0] <= '0;
          corr_r[1] <= '0;
        end
        ST_ERR:  e_r   <= e_sat[23:0];
        ST_IDIV: i_r   <= i_new[19:0];
        ST_DDIV: d_r   <= div_q;
        ST_KP:   acc_r <= mul_p;
        ST_KI:   acc_r <= acc_sum;
        ST_KD:   corr_r[ax] <= u_new[13:0];
        ST_PULSE: pulse_r[ax] <= (pul_sum > PULSE_TOP) ? PULSE_TOP[11:0] : pul_sum[11:0];
        ST_IDLE, ST_IMUL, ST_DMUL, ST_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result register: frees the sequencer while the word waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && cmd.step == ST_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.step == ST_OUT) begin
      o_ang_h_r <= angle_r[0];
      o_ang_v_r <= angle_r[1];
      o_pul_h_r <= pulse_r[0];
      o_pul_v_r <= pulse_r[1];
      o_cor_h_r <= corr_r[0];
      o_cor_v_r <= corr_r[1];
      o_lost_r  <= lost;
    end
  end

  assign sts.unit_done = mul_done || div_done;
  assign sts.lost      = lost;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign angle_h      = o_ang_h_r;
  assign angle_v      = o_ang_v_r;
  assign pulse_h      = o_pul_h_r;
  assign pulse_v      = o_pul_v_r;
  assign correction_h = o_cor_h_r;
  assign correction_v = o_cor_v_r;
  assign target_lost  = o_lost_r;

  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done)) else $error("both units finished together");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cmd.step == ST_OUT) |-> sts.out_free)
    else $error("result register overwritten");
  a_lost_center: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cmd.step == ST_LOST) |=> angle_r[0] == CENTRE_ANGLE)
    else $error("lost frame did not centre");
endmodule

// File: bench/dual_axis_pid_tracker_tb.sv
// Self-checking bench for the dual axis PID tracker: drives frame words,
// predicts every result word in a local PID model and compares field by field.
// Depends on dapt_pkg, dapt_if.sv and the tracker RTL.
`timescale 1ns / 1ps
module dual_axis_pid_tracker_tb;
  import dapt_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] mx, wx, my, wy;
    logic [31:0]      tick;
  } frame_t;

  typedef struct {
    logic [15:0]        ang_h, ang_v;
    logic [11:0]        pul_h, pul_v;
    logic signed [13:0] corr_h, corr_v;
    logic               lost;
  } servo_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  dapt_in_if in_ch();
  dapt_out_if out_ch();

  dual_axis_pid_tracker u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // model copy of the registers and tracker state
  longint kp, ki, kd, pscale, clim, ilim, a_floor, a_ceil;
  longint integ_h, integ_v, last_err_h, last_err_v;
  logic [31:0] prev_tick;
  longint angle_h, angle_v;

  frame_t frame_q[$];
  servo_word_t servo_q[$];
  frame_t cur_frame;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int fails = 0;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint pid_axis(longint perr, inout longint integ,
                                      inout longint prev_e, input longint dt);
    longint e, i, d, acc;
    e = clampl(floor_div(perr * pscale, 256), -64'sd8388608, 64'sd8388607);
    i = clampl(integ + floor_div(e * dt, 1000), -ilim, ilim);
    d = floor_div((e - prev_e) * 1000, dt);
    acc = kp * e + ki * i + kd * d;
    integ = i;
    prev_e = e;
    return clampl(floor_div(acc, 4096), -clim, clim);
  endfunction

  function automatic longint step_angle(longint a, longint u);
    longint t;
    t = a + u;
    if (t < a_floor) return a_floor;
    if (t > a_ceil) return a_ceil;
    return t;
  endfunction

  function automatic logic [11:0] angle_to_pulse(longint a);
    longint p;
    p = a * 2000 / 46080 + 500;
    return (p > 2500) ? 12'd2500 : p[11:0];
  endfunction

  function automatic servo_word_t track_frame(frame_t f);
    servo_word_t r;
    logic [31:0] dt32;
    longint uh, uv;
    uh = 0;
    uv = 0;
    r.lost = (f.mx == 0) && (f.my == 0);
    if (r.lost) begin
      integ_h = 0; integ_v = 0; last_err_h = 0; last_err_v = 0;
      prev_tick = f.tick;
      angle_h = CENTRE_ANGLE;
      angle_v = CENTRE_ANGLE;
    end else begin
      dt32 = f.tick - prev_tick;
      if (dt32 < 5) dt32 = 5;
      if (dt32 > 100) dt32 = 100;
      prev_tick = f.tick;
      uh = pid_axis(longint'(f.wx) - longint'(f.mx), integ_h, last_err_h, dt32);
      uv = pid_axis(longint'(f.wy) - longint'(f.my), integ_v, last_err_v, dt32);
      angle_h = step_angle(angle_h, uh);
      angle_v = step_angle(angle_v, uv);
    end
    r.ang_h = angle_h[15:0];
    r.ang_v = angle_v[15:0];
    r.pul_h = angle_to_pulse(angle_h);
    r.pul_v = angle_to_pulse(angle_v);
    r.corr_h = uh[13:0];
    r.corr_v = uv[13:0];
    return r;
  endfunction

  // driver: push accepted frames through the model, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) servo_q.push_back(track_frame(cur_frame));
      if (!in_ch.valid || in_ch.ready) begin
        if (frame_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_frame = frame_q.pop_front();
          in_ch.measured_x <= cur_frame.mx;
          in_ch.wanted_x <= cur_frame.wx;
          in_ch.measured_y <= cur_frame.my;
          in_ch.wanted_y <= cur_frame.wy;
          in_ch.tick_ms <= cur_frame.tick;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    servo_word_t x;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (servo_q.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          x = servo_q.pop_front();
          if (out_ch.angle_h !== x.ang_h) begin
            $error("angle_h expected %0d got %0d", x.ang_h, out_ch.angle_h); fails++;
          end
          if (out_ch.angle_v !== x.ang_v) begin
            $error("angle_v expected %0d got %0d", x.ang_v, out_ch.angle_v); fails++;
          end
          if (out_ch.pulse_h !== x.pul_h) begin
            $error("pulse_h expected %0d got %0d", x.pul_h, out_ch.pulse_h); fails++;
          end
          if (out_ch.pulse_v !== x.pul_v) begin
            $error("pulse_v expected %0d got %0d", x.pul_v, out_ch.pulse_v); fails++;
          end
          if (out_ch.correction_h !== x.corr_h) begin
            $error("correction_h expected %0d got %0d", x.corr_h, out_ch.correction_h);
            fails++;
          end
          if (out_ch.correction_v !== x.corr_v) begin
            $error("correction_v expected %0d got %0d", x.corr_v, out_ch.correction_v);
            fails++;
          end
          if (out_ch.target_lost !== x.lost) begin
            $error("target_lost expected %0d got %0d", x.lost, out_ch.target_lost); fails++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.measured_x = '0;
    in_ch.wanted_x = '0;
    in_ch.measured_y = '0;
    in_ch.wanted_y = '0;
    in_ch.tick_ms = '0;
    out_ch.ready = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("dual_axis_pid_tracker_tb NOT OK");
    $finish;
  end

  task automatic drain();
    while (frame_q.size() > 0 || in_ch.valid || servo_q.size() > 0) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, longint v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    case (idx)
      CFG_KP:    kp = v & 16'hFFFF;
      CFG_KI:    ki = v & 16'hFFFF;
      CFG_KD:    kd = v & 16'hFFFF;
      CFG_SCALE: pscale = v & 16'hFFFF;
      CFG_CLIM:  clim = v & 13'h1FFF;
      CFG_ILIM:  ilim = v & 18'h3FFFF;
      CFG_FLOOR: a_floor = v & 16'hFFFF;
      default:   a_ceil = v & 16'hFFFF;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(longint g_p, longint g_i, longint g_d, longint sc,
                         longint cl, longint il, longint fl, longint ce);
    drain();
    repeat (600) @(posedge clk);
    set_reg(CFG_KP, g_p);
    set_reg(CFG_KI, g_i);
    set_reg(CFG_KD, g_d);
    set_reg(CFG_SCALE, sc);
    set_reg(CFG_CLIM, cl);
    set_reg(CFG_ILIM, il);
    set_reg(CFG_FLOOR, fl);
    set_reg(CFG_CEIL, ce);
  endtask

  function automatic frame_t mk(int mx, int wx, int my, int wy, logic [31:0] t);
    frame_t f;
    f.mx = PIX_W'(mx); f.wx = PIX_W'(wx); f.my = PIX_W'(my); f.wy = PIX_W'(wy);
    f.tick = t;
    return f;
  endfunction

  function automatic int near_px(int w);
    return int'(clampl(longint'(w) + longint'($urandom_range(120)) - 60, 0, 4095));
  endfunction

  logic [31:0] tick_now = 0;

  task automatic queue_random(int n);
    frame_t f;
    int sel;
    repeat (n) begin
      sel = $urandom_range(99);
      f.wx = PIX_W'($urandom_range(4095));
      f.wy = PIX_W'($urandom_range(4095));
      if (sel < 30) begin
        f.mx = PIX_W'($urandom_range(4095));
        f.my = PIX_W'($urandom_range(4095));
      end else begin
        f.mx = PIX_W'(near_px(f.wx));
        f.my = PIX_W'(near_px(f.wy));
      end
      if (sel < 6) begin
        f.mx = '0; f.my = '0;
      end else if (sel < 9) begin
        f.mx = '0;
      end else if (sel < 12) begin
        f.my = '0;
      end
      sel = $urandom_range(99);
      if (sel < 85) tick_now += $urandom_range(120);
      else if (sel < 95) tick_now += $urandom_range(1000);
      else tick_now = $urandom;
      f.tick = tick_now;
      frame_q.push_back(f);
    end
  endtask

  initial begin
    kp = 410; ki = 41; kd = 205; pscale = 6554;
    clim = 1280; ilim = 128000; a_floor = 11520; a_ceil = 46080;
    integ_h = 0; integ_v = 0; last_err_h = 0; last_err_v = 0;
    prev_tick = 0; angle_h = CENTRE_ANGLE; angle_v = CENTRE_ANGLE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: centred, extremes, lost target, single zero axis, tick edge cases
    frame_q.push_back(mk(2048, 2048, 1000, 1000, 10));
    frame_q.push_back(mk(1, 4095, 4095, 0, 12));
    frame_q.push_back(mk(1, 4095, 4095, 0, 12));
    frame_q.push_back(mk(4095, 0, 1, 4095, 5000));
    frame_q.push_back(mk(4095, 0, 1, 4095, 5100));
    frame_q.push_back(mk(4095, 0, 1, 4095, 5200));
    frame_q.push_back(mk(0, 3000, 0, 100, 5250));
    frame_q.push_back(mk(0, 4095, 2000, 2100, 5260));
    frame_q.push_back(mk(2000, 1900, 0, 4095, 5263));
    frame_q.push_back(mk(4095, 4095, 4095, 4095, 32'hFFFF_FFF0));
    frame_q.push_back(mk(100, 4095, 100, 4095, 32'h0000_0005));
    frame_q.push_back(mk(100, 4095, 100, 4095, 32'hFFFF_FFFF));
    frame_q.push_back(mk(0, 0, 0, 0, 32'hFFFF_FFFF));
    frame_q.push_back(mk(4095, 1, 4095, 1, 32'd40));
    frame_q.push_back(mk(4095, 1, 4095, 1, 32'd140));
    frame_q.push_back(mk(3000, 1000, 500, 2500, 32'd4000));
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        1: set_all(65535, 65535, 65535, 65535, 7680, 262143, 0, 46080);
        2: set_all(0, 0, 0, 0, 0, 0, 0, 0);
        3: set_all(410, 41, 205, 6554, 7680, 128000, 40000, 20000);
        4, 5: set_all($urandom_range(65535), $urandom_range(4095), $urandom_range(65535),
                      $urandom_range(65535), $urandom_range(7680),
                      $urandom_range(262143), $urandom_range(23040),
                      $urandom_range(46080, 23040));
        6: set_all(410, 41, 205, 6554, 1280, 128000, 11520, 46080);
        default: ;
      endcase
      // idle pattern rotates: receiver-heavy, sender-heavy, none
      case (p % 3)
        0: begin src_idle_pct = 33; snk_idle_pct = 77; end
        1: begin src_idle_pct = 77; snk_idle_pct = 33; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      queue_random(100);
      if (p == 2) hold_req = 1;
      // let the sender pause until every result is back, then continue
      drain();
      queue_random(100);
    end

    drain();
    repeat (600) @(posedge clk);
    if (fails == 0) begin
      $display("dual_axis_pid_tracker_tb OK");
    end else begin
      $display("dual_axis_pid_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule
